>>> rtl/core/chord_tone_synthesizer_top_macros.svh
`ifndef CHORD_TONE_SYNTHESIZER_TOP_MACROS_SVH
`define CHORD_TONE_SYNTHESIZER_TOP_MACROS_SVH
// Assertion shorthands for the tone synthesizer. Both sample on the rising
// edge of clk and are switched off while arst_n is low.

// Same-cycle implication: when trig holds, prop must hold in that cycle.
`define CTG_ASSERT_NOW(lbl, trig, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (prop)) else $error(msg);

// Next-cycle implication: when trig holds, prop must hold in the next cycle.
`define CTG_ASSERT_NEXT(lbl, trig, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (prop)) else $error(msg);

`endif

>>> rtl/core/ctg_pkg.sv
// ----------------------------------------------------------------------------
// ctg_pkg
// Shared widths, codes, constants and types of the chord tone synthesizer.
// ----------------------------------------------------------------------------
package ctg_pkg;

	// Field widths.
	localparam int RATE_W     = 17;
	localparam int STEP_W     = 28;
	localparam int VOL_W      = 9;
	localparam int FREQ_W     = 19;
	localparam int VC_W       = 3;
	localparam int DUR_W      = 16;
	localparam int SAMPLE_W   = 16;
	localparam int OP_W       = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 28;

	// Datapath widths.
	localparam int PHASE_W    = 32;
	localparam int CNT_W      = 23;
	localparam int FADE_W     = 10;
	localparam int Q15_W      = 15;
	localparam int MAG_W      = 18;
	localparam int MUL_B_W    = 15;
	localparam int MUL_P_W    = 52;
	localparam int DIV_NUM_W  = 33;
	localparam int DIV_DEN_W  = 13;
	localparam int MIX_SHIFT  = 23;
	localparam int INC_SHIFT  = 12;

	// Operation codes.
	localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
	localparam logic [OP_W-1:0] OP_START = 2'd1;
	localparam logic [OP_W-1:0] OP_STOP  = 2'd2;

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_VOLUME      = 2'd2;

	// Register reset values.
	localparam logic [RATE_W-1:0] RATE_RESET = 17'd44100;
	localparam logic [STEP_W-1:0] STEP_RESET = 28'd24931631;
	localparam logic [VOL_W-1:0]  VOL_RESET  = 9'd256;
	localparam logic [VOL_W-1:0]  VOL_FULL   = 9'd256;

	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	// Arithmetic constants.
	localparam int AMP       = 30000;
	localparam int FADE_DIV  = 200;
	localparam int MS_PER_S  = 1000;
	localparam int GAP_PCT   = 85;
	localparam int FULL_PCT  = 100;

	// Sine polynomial coefficients (Q16).
	localparam longint SIN_A = 102944;
	localparam longint SIN_B = 42334;
	localparam longint SIN_C = 5223;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOAD,
		ST_MS_GO,
		ST_MS_WAIT,
		ST_SND_GO,
		ST_SND_WAIT,
		ST_GAP_GO,
		ST_GAP_WAIT,
		ST_FADE_GO,
		ST_FADE_WAIT,
		ST_VOICE,
		ST_MUL_GO,
		ST_MUL_WAIT,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_EMIT
	} ctg_state_t;

	typedef struct packed {
		logic load;
		logic step;
		logic clear;
	} ctg_voice_ctl_t;

endpackage

>>> rtl/core/chord_tone_synthesizer_top.sv
// ----------------------------------------------------------------------------
// chord_tone_synthesizer_top
// A tone tick runs a serial division for the fade length, steps every voice
// through the mix, makes three serial multiplier passes and ends with a serial
// division for the final scaling; a gap tick goes straight to the output.
// One request at a time: the next is taken once the result is loaded into the
// output register. A start loads the voices and runs three serial divisions.
// Reset: 44100 Hz, default phase step, full volume; voices clear, block idle.
// ----------------------------------------------------------------------------
module chord_tone_synthesizer_top #(
	parameter int VOICES             = 4,
	parameter int SINE_TABLE_ENTRIES = 1024
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// Request channel.
	input  logic                              item_valid,
	output logic                              item_stall,
	input  logic [ctg_pkg::OP_W-1:0]          operation,
	input  logic [ctg_pkg::FREQ_W-1:0]        freq_a,
	input  logic [ctg_pkg::FREQ_W-1:0]        freq_b,
	input  logic [ctg_pkg::FREQ_W-1:0]        freq_c,
	input  logic [ctg_pkg::FREQ_W-1:0]        freq_d,
	input  logic [ctg_pkg::VC_W-1:0]          voice_count,
	input  logic [ctg_pkg::DUR_W-1:0]         duration_ms,
	input  logic                              gap_after,
	// Result channel.
	output logic                              res_valid,
	input  logic                              res_stall,
	output logic signed [ctg_pkg::SAMPLE_W-1:0] sample,
	output logic                              sounding,
	output logic                              last_of_note,
	output logic                              busy_res,
	// Configuration write channel.
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [ctg_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ctg_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import ctg_pkg::*;

	// Voice counter and voices-in-use widths follow the voice count.
	localparam int VW    = (VOICES > 1) ? $clog2(VOICES) : 1;
	localparam int NW    = $clog2(VOICES + 1);
	localparam int SUM_W = 16 + $clog2(VOICES);

	// Configuration registers.
	logic [RATE_W-1:0] rate_q;
	logic [STEP_W-1:0] step_q;
	logic [VOL_W-1:0]  vol_q;

	// Fields captured from a start request.
	logic [FREQ_W-1:0] freq_q [4];
	logic [DUR_W-1:0]  dur_q;
	logic              gap_q;

	// Note state.
	logic [NW-1:0]     n_q;
	logic [CNT_W-1:0]  pos_q;
	logic [CNT_W-1:0]  snd_q;
	logic [CNT_W-1:0]  gapcnt_q;
	logic              playing_q;
	logic [DUR_W-1:0]  sound_ms_q;

	// Per-tick working registers.
	ctg_state_t        state_q, state_d;
	logic [VW-1:0]     vcnt_q;
	logic [1:0]        pass_q;
	logic              tone_q;
	logic [FADE_W-1:0] env_num_q;
	logic [FADE_W-1:0] env_den_q;
	logic [SAMPLE_W-1:0] sample_q;

	// Output register.
	logic                res_valid_q;
	logic [SAMPLE_W-1:0] sample_o_q;
	logic                sounding_o_q;
	logic                last_o_q;

	// Shared units.
	ctg_voice_ctl_t          vctl;
	logic                    vactive;
	logic [PHASE_W-1:0]      inc_nx;
	logic signed [SUM_W-1:0] vsum;
	logic                    div_start, div_done;
	logic [DIV_NUM_W-1:0]    div_num, div_quo;
	logic [DIV_DEN_W-1:0]    div_den;
	logic                    mul_start, mul_done;
	logic [MUL_P_W-1:0]      mul_a, mul_prod;
	logic [MUL_B_W-1:0]      mul_b;

	// Helper terms.
	logic                      accept;
	logic                      out_free;
	logic                      vlast;
	logic [FREQ_W-1:0]         f_sel;
	logic [FREQ_W+STEP_W-1:0]  inc_prod;
	logic [VOL_W-1:0]          vol_eff;
	logic [NW-1:0]             div_n;
	logic [NW-1:0]             n_clamp;
	logic [MAG_W-1:0]          sum_abs;
	logic [CNT_W-1:0]          left;
	logic [FADE_W-1:0]         fade;
	logic [CNT_W-1:0]          quo_sat;
	logic [DIV_NUM_W-1:0]      mag_cap;
	logic [SAMPLE_W-1:0]       mag16;
	logic [CNT_W-1:0]          pos_nx;
	logic [CNT_W-1:0]          gap_nx;
	logic                      last_nx;

	// Configuration writes land only between requests, while the block idles.
	assign cfg_ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q <= RATE_RESET;
			step_q <= STEP_RESET;
			vol_q  <= VOL_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_SAMPLE_RATE: rate_q <= cfg_data[RATE_W-1:0];
				REG_PHASE_STEP:  step_q <= cfg_data[STEP_W-1:0];
				REG_VOLUME:      vol_q  <= cfg_data[VOL_W-1:0];
				default: ;
			endcase
		end
	end

	// A request is taken only while idle. A finished result may still be
	// waiting in the output register; the next one waits in ST_EMIT.
	assign item_stall = (state_q != ST_IDLE);
	assign accept     = item_valid && (state_q == ST_IDLE);
	assign out_free   = !res_valid_q || !res_stall;
	assign vlast      = (vcnt_q == VW'(VOICES - 1));

	// Frequency of the voice at the head of the ring during a load; voices
	// past the fourth have no frequency port and stay silent.
	always_comb begin
		f_sel = (32'(vcnt_q) < 4) ? freq_q[2'(vcnt_q)] : '0;
		inc_prod = (FREQ_W+STEP_W)'(f_sel) * (FREQ_W+STEP_W)'(step_q);
		inc_nx   = inc_prod[PHASE_W+INC_SHIFT-1:INC_SHIFT];
	end

	always_comb begin
		vol_eff = (vol_q > VOL_FULL) ? VOL_FULL : vol_q;
		div_n   = (n_q == '0) ? NW'(1) : n_q;
		n_clamp = (32'(voice_count) > VOICES) ? NW'(VOICES) : NW'(voice_count);
		sum_abs = vsum[SUM_W-1] ? MAG_W'(-vsum) : MAG_W'(vsum);
		left    = snd_q - pos_q;
		fade    = div_quo[FADE_W-1:0];
		quo_sat = (div_quo > DIV_NUM_W'(CNT_MAX)) ? CNT_MAX : div_quo[CNT_W-1:0];
		mag_cap = (div_quo > DIV_NUM_W'(AMP)) ? DIV_NUM_W'(AMP) : div_quo;
		mag16   = mag_cap[SAMPLE_W-1:0];
		vactive = (32'(vcnt_q) < 32'(n_q));
	end

	// Operands of the shared divider and multiplier, chosen by state.
	always_comb begin
		div_num = DIV_NUM_W'(rate_q);
		div_den = DIV_DEN_W'(FADE_DIV);
		unique case (state_q)
			ST_MS_GO: begin
				div_num = DIV_NUM_W'(dur_q) * DIV_NUM_W'(gap_q ? GAP_PCT : FULL_PCT);
				div_den = DIV_DEN_W'(FULL_PCT);
			end
			ST_SND_GO: begin
				div_num = DIV_NUM_W'(rate_q) * DIV_NUM_W'(sound_ms_q);
				div_den = DIV_DEN_W'(MS_PER_S);
			end
			ST_GAP_GO: begin
				div_num = DIV_NUM_W'(rate_q) * DIV_NUM_W'(dur_q - sound_ms_q);
				div_den = DIV_DEN_W'(MS_PER_S);
			end
			ST_DIV_GO: begin
				div_num = DIV_NUM_W'(mul_prod >> MIX_SHIFT);
				div_den = DIV_DEN_W'(div_n) * DIV_DEN_W'(env_den_q);
			end
			default: ;
		endcase
	end

	always_comb begin
		mul_a = (pass_q == 2'd0) ? MUL_P_W'(sum_abs) : mul_prod;
		unique case (pass_q)
			2'd0:    mul_b = MUL_B_W'(env_num_q);
			2'd1:    mul_b = MUL_B_W'(vol_eff);
			default: mul_b = MUL_B_W'(AMP);
		endcase
	end

	// Next state and unit strobes.
	always_comb begin
		state_d    = state_q;
		vctl       = '0;
		div_start  = 1'b0;
		mul_start  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (operation == OP_START) begin
						state_d = ST_LOAD;
					end else if (operation == OP_TICK && playing_q) begin
						state_d = (pos_q < snd_q) ? ST_FADE_GO : ST_EMIT;
					end
				end
			end
			ST_LOAD: begin
				vctl.load = 1'b1;
				if (vlast) state_d = ST_MS_GO;
			end
			ST_MS_GO: begin
				div_start = 1'b1;
				state_d   = ST_MS_WAIT;
			end
			ST_MS_WAIT:  if (div_done) state_d = ST_SND_GO;
			ST_SND_GO: begin
				div_start = 1'b1;
				state_d   = ST_SND_WAIT;
			end
			ST_SND_WAIT: if (div_done) state_d = ST_GAP_GO;
			ST_GAP_GO: begin
				div_start = 1'b1;
				state_d   = ST_GAP_WAIT;
			end
			ST_GAP_WAIT: if (div_done) state_d = ST_IDLE;
			ST_FADE_GO: begin
				div_start  = 1'b1;
				vctl.clear = 1'b1;
				state_d    = ST_FADE_WAIT;
			end
			ST_FADE_WAIT: if (div_done) state_d = ST_VOICE;
			ST_VOICE: begin
				vctl.step = 1'b1;
				if (vlast) state_d = ST_MUL_GO;
			end
			ST_MUL_GO: begin
				mul_start = 1'b1;
				state_d   = ST_MUL_WAIT;
			end
			ST_MUL_WAIT: begin
				if (mul_done) state_d = (pass_q == 2'd2) ? ST_DIV_GO : ST_MUL_GO;
			end
			ST_DIV_GO: begin
				div_start = 1'b1;
				state_d   = ST_DIV_WAIT;
			end
			ST_DIV_WAIT: if (div_done) state_d = ST_EMIT;
			ST_EMIT:     if (out_free) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Position and gap count after the tick being emitted.
	always_comb begin
		pos_nx  = pos_q + 1'b1;
		gap_nx  = (gapcnt_q != '0) ? gapcnt_q - 1'b1 : gapcnt_q;
		last_nx = tone_q ? (pos_nx == snd_q && gapcnt_q == '0) : (gap_nx == '0);
	end

	// Control and note state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcnt_q      <= '0;
			pass_q      <= '0;
			tone_q      <= 1'b0;
			n_q         <= '0;
			pos_q       <= '0;
			snd_q       <= '0;
			gapcnt_q    <= '0;
			playing_q   <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_EMIT && out_free) res_valid_q <= 1'b1;
			else if (res_valid_q && !res_stall) res_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					vcnt_q <= '0;
					if (accept) begin
						if (operation == OP_START) begin
							n_q <= n_clamp;
						end else if (operation == OP_STOP) begin
							playing_q <= 1'b0;
							gapcnt_q  <= '0;
						end else if (operation == OP_TICK) begin
							tone_q <= (pos_q < snd_q);
						end
					end
				end
				ST_LOAD, ST_VOICE: begin
					vcnt_q <= vlast ? '0 : vcnt_q + 1'b1;
					pass_q <= '0;
				end
				ST_SND_WAIT: if (div_done) snd_q <= quo_sat;
				ST_GAP_WAIT: begin
					if (div_done) begin
						gapcnt_q  <= gap_q ? quo_sat : '0;
						pos_q     <= '0;
						playing_q <= (snd_q != '0) || (gap_q && quo_sat != '0);
					end
				end
				ST_MUL_WAIT: if (mul_done) pass_q <= pass_q + 1'b1;
				ST_EMIT: begin
					if (out_free) begin
						if (tone_q) pos_q <= pos_nx;
						else        gapcnt_q <= gap_nx;
						if (last_nx) playing_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (accept && operation == OP_START) begin
			freq_q[0] <= freq_a;
			freq_q[1] <= freq_b;
			freq_q[2] <= freq_c;
			freq_q[3] <= freq_d;
			dur_q     <= duration_ms;
			gap_q     <= gap_after;
		end
		if (state_q == ST_MS_WAIT && div_done) sound_ms_q <= div_quo[DUR_W-1:0];
		// Fade: ramp up over the first samples, down over the last ones.
		if (state_q == ST_FADE_WAIT && div_done) begin
			if (pos_q < CNT_W'(fade)) begin
				env_num_q <= pos_q[FADE_W-1:0];
				env_den_q <= fade;
			end else if (left < CNT_W'(fade)) begin
				env_num_q <= left[FADE_W-1:0];
				env_den_q <= fade;
			end else begin
				env_num_q <= FADE_W'(1);
				env_den_q <= FADE_W'(1);
			end
		end
		if (state_q == ST_DIV_WAIT && div_done) begin
			sample_q <= vsum[SUM_W-1] ? SAMPLE_W'(0) - mag16 : mag16;
		end
		if (state_q == ST_EMIT && out_free) begin
			sample_o_q   <= tone_q ? sample_q : '0;
			sounding_o_q <= tone_q;
			last_o_q     <= last_nx;
		end
	end

	assign res_valid    = res_valid_q;
	assign sample       = sample_o_q;
	assign sounding     = sounding_o_q;
	assign last_of_note = last_o_q;
	assign busy_res     = res_valid_q;

	ctg_voice_bank #(
		.VOICES       (VOICES),
		.SINE_ENTRIES (SINE_TABLE_ENTRIES),
		.SUM_W        (SUM_W)
	) u_voices (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (vctl),
		.active (vactive),
		.inc_in (inc_nx),
		.sum    (vsum)
	);

	ctg_serial_div #(
		.NUM_W (DIV_NUM_W),
		.DEN_W (DIV_DEN_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	ctg_serial_mul #(
		.P_W (MUL_P_W),
		.B_W (MUL_B_W)
	) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.prod   (mul_prod)
	);

endmodule

>>> rtl/core/ctg_serial_div.sv
// ----------------------------------------------------------------------------
// ctg_serial_div
// Restoring divider, one quotient bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module ctg_serial_div #(
	parameter int NUM_W = 33,
	parameter int DEN_W = 13
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quo
);
	localparam int CW = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W:0]   rem_q;
	logic [CW-1:0]    cnt_q;
	logic             run_q;
	logic             done_q;
	logic [DEN_W:0]   rem_sh;
	logic             ge;
	logic [DEN_W:0]   rem_nx;

	always_comb begin
		rem_sh = {rem_q[DEN_W-1:0], quo_q[NUM_W-1]};
		ge     = rem_sh >= {1'b0, den_q};
		rem_nx = ge ? rem_sh - {1'b0, den_q} : rem_sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			run_q  <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (run_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CW'(NUM_W - 1)) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (run_q) begin
			rem_q <= rem_nx;
			quo_q <= {quo_q[NUM_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

>>> rtl/core/ctg_serial_mul.sv
// ----------------------------------------------------------------------------
// ctg_serial_mul
// Shift-add multiplier, one multiplier bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module ctg_serial_mul #(
	parameter int P_W = 52,
	parameter int B_W = 15
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [P_W-1:0] a,
	input  logic [B_W-1:0] b,
	output logic           done,
	output logic [P_W-1:0] prod
);
	localparam int CW = $clog2(B_W + 1);

	logic [P_W-1:0] acc_q;
	logic [P_W-1:0] a_q;
	logic [B_W-1:0] b_q;
	logic [CW-1:0]  cnt_q;
	logic           run_q;
	logic           done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			run_q  <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (run_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CW'(B_W - 1)) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			a_q   <= a;
			b_q   <= b;
		end else if (run_q) begin
			acc_q <= {acc_q[P_W-2:0], 1'b0} + (b_q[B_W-1] ? a_q : '0);
			b_q   <= {b_q[B_W-2:0], 1'b0};
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule

>>> rtl/core/ctg_voice_bank.sv
// ----------------------------------------------------------------------------
// ctg_voice_bank
// Rotating ring of voice phase accumulators with a quarter-wave sine table
// and a mix accumulator; one voice passes the head per cycle while it loads or steps.
// ----------------------------------------------------------------------------
module ctg_voice_bank #(
	parameter int VOICES       = 4,
	parameter int SINE_ENTRIES = 1024,
	parameter int SUM_W        = 18
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  ctg_pkg::ctg_voice_ctl_t        ctl,
	input  logic                           active,
	input  logic [ctg_pkg::PHASE_W-1:0]    inc_in,
	output logic signed [SUM_W-1:0]        sum
);
	import ctg_pkg::*;

	localparam int LOG_E  = $clog2(SINE_ENTRIES);
	localparam int QUART  = SINE_ENTRIES / 4;
	localparam int TIDX_W = LOG_E - 1;

	typedef logic [Q15_W-1:0] sine_tab_t [QUART];

	// Quarter wave, built at elaboration from the polynomial. The peak at a
	// quarter turn always lands on full scale and is not stored.
	function automatic sine_tab_t build_tab();
		sine_tab_t t;
		longint z, z2, p, y;
		for (int i = 0; i < QUART; i++) begin
			z  = (longint'(i) <<< 18) / SINE_ENTRIES;
			z2 = (z * z) >>> 16;
			p  = SIN_B - ((SIN_C * z2) >>> 16);
			p  = SIN_A - ((p * z2) >>> 16);
			y  = (z * p) >>> 16;
			y  = (y + 1) >>> 1;
			if (y > 32767) y = 32767;
			t[i] = Q15_W'(y);
		end
		return t;
	endfunction

	localparam sine_tab_t SINE_TAB = build_tab();

	logic [PHASE_W-1:0]      phase_q [VOICES];
	logic [PHASE_W-1:0]      inc_q   [VOICES];
	logic [PHASE_W-1:0]      head_phase_nx;
	logic [PHASE_W-1:0]      head_inc_nx;
	logic signed [SUM_W-1:0] sum_q;
	logic [LOG_E-1:0]        idx;
	logic [1:0]              quad;
	logic [TIDX_W-1:0]       tidx;
	logic [Q15_W-1:0]        mag;
	logic signed [15:0]      sval;

	always_comb begin
		idx  = phase_q[0][PHASE_W-1 -: LOG_E];
		quad = idx[LOG_E-1 -: 2];
		tidx = {1'b0, idx[LOG_E-3:0]};
		if (quad[0]) tidx = TIDX_W'(QUART) - tidx;
		mag  = (tidx == TIDX_W'(QUART)) ? {Q15_W{1'b1}} : SINE_TAB[tidx[TIDX_W-2:0]];
		sval = quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
	end

	always_comb begin
		head_phase_nx = phase_q[0];
		head_inc_nx   = inc_q[0];
		if (ctl.load) begin
			head_phase_nx = '0;
			head_inc_nx   = inc_in;
		end else if (ctl.step && active) begin
			head_phase_nx = phase_q[0] + inc_q[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < VOICES; i++) begin
				phase_q[i] <= '0;
				inc_q[i]   <= '0;
			end
		end else if (ctl.load || ctl.step) begin
			for (int i = 0; i < VOICES - 1; i++) begin
				phase_q[i] <= phase_q[i+1];
				inc_q[i]   <= inc_q[i+1];
			end
			phase_q[VOICES-1] <= head_phase_nx;
			inc_q[VOICES-1]   <= head_inc_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.clear) begin
			sum_q <= '0;
		end else if (ctl.step && active) begin
			sum_q <= sum_q + SUM_W'(sval);
		end
	end

	assign sum = sum_q;

endmodule

>>> rtl/core/ctg_checker.sv
// ----------------------------------------------------------------------------
// ctg_checker
// Port-level checks of the tone synthesizer, bound to the top level.
// ----------------------------------------------------------------------------
`include "chord_tone_synthesizer_top_macros.svh"

module ctg_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                item_valid,
	input logic                                item_stall,
	input logic [ctg_pkg::OP_W-1:0]            operation,
	input logic [ctg_pkg::FREQ_W-1:0]          freq_a,
	input logic [ctg_pkg::FREQ_W-1:0]          freq_b,
	input logic [ctg_pkg::FREQ_W-1:0]          freq_c,
	input logic [ctg_pkg::FREQ_W-1:0]          freq_d,
	input logic [ctg_pkg::VC_W-1:0]            voice_count,
	input logic [ctg_pkg::DUR_W-1:0]           duration_ms,
	input logic                                gap_after,
	input logic                                res_valid,
	input logic                                res_stall,
	input logic signed [ctg_pkg::SAMPLE_W-1:0] sample,
	input logic                                sounding,
	input logic                                last_of_note,
	input logic                                busy_res,
	input logic                                cfg_valid,
	input logic                                cfg_ready,
	input logic [ctg_pkg::CFG_IDX_W-1:0]       cfg_index,
	input logic [ctg_pkg::CFG_DATA_W-1:0]      cfg_data
);

	// A stalled result holds its sample.
	`CTG_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(sample), "result dropped or changed while stalled")

	// A taken start keeps the block busy while the note is set up.
	`CTG_ASSERT_NEXT(a_one_at_a_time, item_valid && !item_stall && operation == ctg_pkg::OP_START, item_stall, "request taken while another is in flight")

	// A fresh result only follows work in progress.
	`CTG_ASSERT_NOW(a_result_from_work, $rose(res_valid), $past(item_stall), "result appeared without a request")

	// Gap samples are silent and tone samples stay within plus or minus 30000.
	`CTG_ASSERT_NOW(a_sample_range, res_valid, (sounding || sample == 16'sd0) && $signed(sample) <= 16'sd30000 && $signed(sample) >= -16'sd30000, "sample outside its range")

endmodule

bind chord_tone_synthesizer_top ctg_checker u_ctg_checker (.*);
